### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on clk_i and stay
// quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define GLS_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define GLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/gls_pkg.sv
// ----------------------------------------------------------------------------
// gls_pkg
// Types, codes and helpers shared by the grid Laplacian stencil engine.
// ----------------------------------------------------------------------------
package gls_pkg;

  localparam int unsigned GlsMaxDim   = 16;
  localparam int unsigned GlsFracBits = 16;
  localparam int unsigned CfgAddrW    = 5;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned IdxW        = 15;
  localparam int unsigned AccW        = 128;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_SAMPLE   = 2'd1,
    OP_LAPLACE  = 2'd2,
    OP_INTEGRAL = 2'd3
  } gls_op_e;

  typedef enum logic [1:0] {
    BND_ZERO  = 2'd0,
    BND_WRAP  = 2'd1,
    BND_CLAMP = 2'd2
  } bnd_mode_e;

  typedef enum logic [2:0] {
    REG_SIZE_X      = 3'd0,
    REG_SIZE_Y      = 3'd1,
    REG_SIZE_Z      = 3'd2,
    REG_INV_DX_SQ   = 3'd3,
    REG_INV_DY_SQ   = 3'd4,
    REG_INV_DZ_SQ   = 3'd5,
    REG_CELL_VOLUME = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MAC_IDLE   = 2'd0,
    MAC_MUL_LO = 2'd1,
    MAC_MUL_HI = 2'd2,
    MAC_ACC    = 2'd3
  } mac_op_e;

  typedef struct packed {
    logic    clear;
    mac_op_e op;
  } mac_cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WRAP,
    ST_READ,
    ST_SAMPLE_DATA,
    ST_LAP_READ,
    ST_LAP_DATA,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_ACC,
    ST_INT_RUN,
    ST_INT_TAIL,
    ST_ROUND,
    ST_DONE
  } gls_state_e;

  function automatic logic [4:0] eff_extent(logic [4:0] r, int unsigned max_dim);
    logic [4:0] e;
    e = r;
    if (r == 5'd0) begin
      e = 5'd1;
    end else if (32'(r) > max_dim) begin
      e = 5'(max_dim);
    end
    return e;
  endfunction

endpackage

### rtl/gls_if.sv
// ----------------------------------------------------------------------------
// gls_in_if / gls_out_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface gls_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [7:0]  coord_x;
  logic signed [7:0]  coord_y;
  logic signed [7:0]  coord_z;
  logic [1:0]         boundary_mode;
  logic signed [31:0] write_value;

  modport source (output valid, operation, coord_x, coord_y, coord_z, boundary_mode,
                  write_value, input ready);
  modport sink (input valid, operation, coord_x, coord_y, coord_z, boundary_mode,
                write_value, output ready);
endinterface

interface gls_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic               status;

  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

### rtl/gls_store.sv
// ----------------------------------------------------------------------------
// gls_store
// Grid cell memory with one write and one registered read port, swept to
// zero one cell per cycle after reset.
// ----------------------------------------------------------------------------
module gls_store import gls_pkg::*; #(
  parameter int unsigned DEPTH = GlsMaxDim * GlsMaxDim * GlsMaxDim,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o,
  output logic          ready_o
);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_q;
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_data;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    mem_we   = clr_busy_q || we_i;
    mem_addr = clr_busy_q ? clr_addr_q : waddr_i;
    mem_data = clr_busy_q ? 32'd0 : wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

### rtl/gls_rem_unit.sv
// ----------------------------------------------------------------------------
// gls_rem_unit
// Bit-serial floored remainder of a signed coordinate by a grid extent,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gls_rem_unit import gls_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic signed [7:0] coord_i,
  input  logic [4:0]       extent_i,
  output logic             done_o,
  output logic [4:0]       rem_o
);

  logic       busy_q, busy_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] mag_q, mag_d;
  logic [4:0] rem_q, rem_d;
  logic [4:0] n_q, n_d;
  logic       neg_q, neg_d;
  logic       done_q, done_d;
  logic [5:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    n_d    = n_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    trial  = {rem_q, mag_q[7]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd7;
      mag_d  = coord_i[7] ? 8'(-coord_i) : coord_i;
      rem_d  = 5'd0;
      n_d    = extent_i;
      neg_d  = coord_i[7];
    end else if (busy_q) begin
      mag_d = {mag_q[6:0], 1'b0};
      rem_d = (trial >= {1'b0, n_q}) ? 5'(trial - {1'b0, n_q}) : trial[4:0];
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    n_q   <= n_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign rem_o  = (neg_q && rem_q != 5'd0) ? n_q - rem_q : rem_q;

endmodule

### rtl/gls_mac.sv
// ----------------------------------------------------------------------------
// gls_mac
// Shared 33x33 signed multiplier and wide accumulator that scales a 64-bit
// signed operand by a 32-bit unsigned factor in two partial products, then
// rounds and saturates the sum.
// ----------------------------------------------------------------------------
module gls_mac import gls_pkg::*; #(
  parameter int unsigned FRAC_BITS = GlsFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_cmd_t           cmd_i,
  input  logic signed [63:0] opnd_i,
  input  logic [31:0]        factor_i,
  output logic signed [63:0] result_o
);

  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [65:0]     prod_q, prod_d;
  logic                   hi_q, hi_d;
  logic signed [32:0]     mul_a;
  logic signed [32:0]     mul_b;
  logic signed [AccW-1:0] addend;
  logic signed [AccW-1:0] rnd;
  logic signed [AccW-1:0] shr;
  logic                   fits;

  always_comb begin
    mul_a = (cmd_i.op == MAC_MUL_HI) ? {opnd_i[63], opnd_i[63:32]} : {1'b0, opnd_i[31:0]};
    mul_b = {1'b0, factor_i};
    addend = hi_q ? {{30{prod_q[65]}}, prod_q, 32'd0} : {{62{prod_q[65]}}, prod_q};
    acc_d  = acc_q;
    prod_d = prod_q;
    hi_d   = hi_q;
    case (cmd_i.op)
      MAC_MUL_LO: begin
        prod_d = mul_a * mul_b;
        hi_d   = 1'b0;
      end
      MAC_MUL_HI: begin
        acc_d  = acc_q + addend;
        prod_d = mul_a * mul_b;
        hi_d   = 1'b1;
      end
      MAC_ACC: begin
        acc_d = acc_q + addend;
      end
      default: begin
      end
    endcase
    if (cmd_i.clear) begin
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= 1'b0;
    end else begin
      hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  always_comb begin
    rnd  = acc_q + (AccW'(1) <<< (FRAC_BITS - 1));
    shr  = rnd >>> FRAC_BITS;
    fits = (&shr[AccW-1:63]) || !(|shr[AccW-1:63]);
    if (fits) begin
      result_o = shr[63:0];
    end else if (shr[AccW-1]) begin
      result_o = {1'b1, 63'd0};
    end else begin
      result_o = {1'b0, {63{1'b1}}};
    end
  end

endmodule

### rtl/grid_laplacian_stencil_engine_core.sv
// ----------------------------------------------------------------------------
// grid_laplacian_stencil_engine_core
// Grid store with cell write, boundary sample, 7-point Laplacian and
// volume integral, run by a sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
// Command words arrive on in_i and each gives exactly one result word on
// out_o (value and status). Registers are written through the APB port
// while the block is idle; the user must keep to this, as the block does
// not enforce it. pready is always high. After reset the cell store is
// swept to zero, one cell per cycle, over all MAX_DIM**3 cells (4096 by
// default); in_i.ready stays low meanwhile. One word is in flight at a
// time. A wrapped sample runs three serial remainders, a Laplacian makes
// seven reads of the single store port plus three multiplies, and an
// integral reads one cell per cycle. A finished result waits in the
// output register while the next word is accepted; if the receiver
// stalls, the following result waits in the sequencer until the output
// register frees.
// ----------------------------------------------------------------------------
module grid_laplacian_stencil_engine_core import gls_pkg::*; #(
  parameter int unsigned MAX_DIM   = GlsMaxDim,
  parameter int unsigned FRAC_BITS = GlsFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  gls_in_if.sink              in_i,
  gls_out_if.source           out_o
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  gls_state_e state_q, state_d;

  logic [4:0]  size_x_q, size_y_q, size_z_q;
  logic [31:0] inv_dx_q, inv_dy_q, inv_dz_q, volume_q;
  logic        cfg_we;

  gls_op_e            op_q;
  bnd_mode_e          mode_q;
  logic signed [7:0]  cx_q, cy_q, cz_q;
  logic [31:0]        wval_q;
  logic [4:0]         rx_q, ry_q, rz_q, rx_d, ry_d, rz_d;
  logic [2:0]         k_q, k_d;
  logic [1:0]         ax_q, ax_d;
  logic signed [63:0] sum_q, sum_d;
  logic signed [31:0] c_q, c_d;
  logic               zero_q, zero_d;
  logic [IdxW-1:0]    cnt_q, cnt_d;
  logic signed [63:0] hold_q, hold_d;
  logic               hstat_q, hstat_d;
  logic               accept;

  logic               out_valid_q, out_valid_d;
  logic signed [63:0] out_val_q;
  logic               out_stat_q;
  logic               out_load;

  logic [4:0]      nx, ny, nz;
  logic            in_grid;
  logic [4:0]      qx, qy, qz;
  logic [9:0]      zy;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] cells;

  logic            st_we;
  logic [AW-1:0]   st_raddr;
  logic [31:0]     st_rdata;
  logic            store_ready;
  logic signed [63:0] st_sample;

  mac_cmd_t           mac_cmd;
  logic [31:0]        mac_factor;
  logic signed [63:0] mac_result;

  logic              rem_start;
  logic signed [7:0] rem_coord;
  logic [4:0]        rem_ext;
  logic              rem_done;
  logic [4:0]        rem_val;

  logic [4:0] nb_base, nb_n, nb_coord;
  logic       nb_left, nb_out, nb_zero;
  logic [1:0] nb_axis;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (cfg_reg_e'(paddr[4:2]))
      REG_SIZE_X:      prdata = {27'd0, size_x_q};
      REG_SIZE_Y:      prdata = {27'd0, size_y_q};
      REG_SIZE_Z:      prdata = {27'd0, size_z_q};
      REG_INV_DX_SQ:   prdata = inv_dx_q;
      REG_INV_DY_SQ:   prdata = inv_dy_q;
      REG_INV_DZ_SQ:   prdata = inv_dz_q;
      REG_CELL_VOLUME: prdata = volume_q;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 5'd16;
      size_y_q <= 5'd16;
      size_z_q <= 5'd16;
      inv_dx_q <= 32'd65536;
      inv_dy_q <= 32'd65536;
      inv_dz_q <= 32'd65536;
      volume_q <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_reg_e'(paddr[4:2]))
        REG_SIZE_X:      size_x_q <= pwdata[4:0];
        REG_SIZE_Y:      size_y_q <= pwdata[4:0];
        REG_SIZE_Z:      size_z_q <= pwdata[4:0];
        REG_INV_DX_SQ:   inv_dx_q <= pwdata;
        REG_INV_DY_SQ:   inv_dy_q <= pwdata;
        REG_INV_DZ_SQ:   inv_dz_q <= pwdata;
        REG_CELL_VOLUME: volume_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Geometry
  assign nx = eff_extent(size_x_q, MAX_DIM);
  assign ny = eff_extent(size_y_q, MAX_DIM);
  assign nz = eff_extent(size_z_q, MAX_DIM);

  assign in_grid = !cx_q[7] && (cx_q[6:0] < {2'b00, nx}) &&
                   !cy_q[7] && (cy_q[6:0] < {2'b00, ny}) &&
                   !cz_q[7] && (cz_q[6:0] < {2'b00, nz});

  always_comb begin
    nb_left = k_q[0];
    case (k_q)
      3'd1, 3'd2: nb_axis = 2'd0;
      3'd3, 3'd4: nb_axis = 2'd1;
      default:    nb_axis = 2'd2;
    endcase
    case (nb_axis)
      2'd0:    begin nb_base = rx_q; nb_n = nx; end
      2'd1:    begin nb_base = ry_q; nb_n = ny; end
      default: begin nb_base = rz_q; nb_n = nz; end
    endcase
    nb_out   = nb_left ? (nb_base == 5'd0)
                       : (({1'b0, nb_base} + 6'd1) == {1'b0, nb_n});
    nb_zero  = 1'b0;
    nb_coord = nb_left ? nb_base - 5'd1 : nb_base + 5'd1;
    if (nb_out) begin
      case (mode_q)
        BND_ZERO: nb_zero  = 1'b1;
        BND_WRAP: nb_coord = nb_left ? nb_n - 5'd1 : 5'd0;
        default:  nb_coord = nb_base;
      endcase
    end
    qx = rx_q;
    qy = ry_q;
    qz = rz_q;
    if (state_q == ST_LAP_READ && k_q != 3'd0) begin
      case (nb_axis)
        2'd0:    qx = nb_coord;
        2'd1:    qy = nb_coord;
        default: qz = nb_coord;
      endcase
    end
  end

  assign zy    = 10'({5'd0, qz} * {5'd0, ny}) + {5'd0, qy};
  assign idx   = IdxW'({5'd0, zy} * {10'd0, nx}) + {10'd0, qx};
  assign cells = IdxW'({5'd0, nx} * {5'd0, ny}) * {10'd0, nz};

  assign st_raddr  = (state_q == ST_INT_RUN) ? AW'(cnt_q) : AW'(idx);
  assign st_sample = {{32{st_rdata[31]}}, st_rdata};

  gls_store #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .waddr_i (AW'(idx)),
    .wdata_i (wval_q),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata),
    .ready_o (store_ready)
  );

  always_comb begin
    case (ax_d)
      2'd0:    begin rem_coord = cx_q; rem_ext = nx; end
      2'd1:    begin rem_coord = cy_q; rem_ext = ny; end
      default: begin rem_coord = cz_q; rem_ext = nz; end
    endcase
  end

  gls_rem_unit u_rem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (rem_start),
    .coord_i  (rem_coord),
    .extent_i (rem_ext),
    .done_o   (rem_done),
    .rem_o    (rem_val)
  );

  always_comb begin
    if (op_q == OP_INTEGRAL) begin
      mac_factor = volume_q;
    end else begin
      case (k_q)
        3'd2:    mac_factor = inv_dx_q;
        3'd4:    mac_factor = inv_dy_q;
        default: mac_factor = inv_dz_q;
      endcase
    end
  end

  gls_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mac_cmd),
    .opnd_i   (sum_q),
    .factor_i (mac_factor),
    .result_o (mac_result)
  );

  // Sequencer
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    rz_d        = rz_q;
    k_d         = k_q;
    ax_d        = ax_q;
    sum_d       = sum_q;
    c_d         = c_q;
    zero_d      = zero_q;
    cnt_d       = cnt_q;
    hold_d      = hold_q;
    hstat_d     = hstat_q;
    st_we       = 1'b0;
    rem_start   = 1'b0;
    mac_cmd     = '{clear: 1'b0, op: MAC_IDLE};
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      ST_CLEAR: begin
        if (store_ready) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rx_d    = in_i.coord_x[4:0];
          ry_d    = in_i.coord_y[4:0];
          rz_d    = in_i.coord_z[4:0];
          k_d     = 3'd0;
          ax_d    = 2'd0;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        hold_d  = '0;
        hstat_d = 1'b0;
        case (op_q)
          OP_WRITE: begin
            st_we   = in_grid;
            hstat_d = !in_grid;
            state_d = ST_DONE;
          end
          OP_SAMPLE: begin
            if (in_grid) begin
              state_d = ST_READ;
            end else begin
              case (mode_q)
                BND_ZERO: state_d = ST_DONE;
                BND_WRAP: begin
                  rem_start = 1'b1;
                  state_d   = ST_WRAP;
                end
                default: begin
                  rx_d = cx_q[7] ? 5'd0 : ((cx_q[6:0] >= {2'b00, nx}) ? nx - 5'd1 : cx_q[4:0]);
                  ry_d = cy_q[7] ? 5'd0 : ((cy_q[6:0] >= {2'b00, ny}) ? ny - 5'd1 : cy_q[4:0]);
                  rz_d = cz_q[7] ? 5'd0 : ((cz_q[6:0] >= {2'b00, nz}) ? nz - 5'd1 : cz_q[4:0]);
                  state_d = ST_READ;
                end
              endcase
            end
          end
          OP_LAPLACE: begin
            if (in_grid) begin
              mac_cmd.clear = 1'b1;
              state_d       = ST_LAP_READ;
            end else begin
              hstat_d = 1'b1;
              state_d = ST_DONE;
            end
          end
          default: begin
            mac_cmd.clear = 1'b1;
            sum_d         = '0;
            cnt_d         = '0;
            state_d       = ST_INT_RUN;
          end
        endcase
      end
      ST_WRAP: begin
        if (rem_done) begin
          case (ax_q)
            2'd0:    rx_d = rem_val;
            2'd1:    ry_d = rem_val;
            default: rz_d = rem_val;
          endcase
          if (ax_q == 2'd2) begin
            state_d = ST_READ;
          end else begin
            ax_d      = ax_q + 2'd1;
            rem_start = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_d = ST_SAMPLE_DATA;
      end
      ST_SAMPLE_DATA: begin
        hold_d  = st_sample;
        state_d = ST_DONE;
      end
      ST_LAP_READ: begin
        zero_d  = (k_q != 3'd0) && nb_zero;
        state_d = ST_LAP_DATA;
      end
      ST_LAP_DATA: begin
        if (k_q == 3'd0) begin
          c_d     = st_rdata;
          k_d     = 3'd1;
          state_d = ST_LAP_READ;
        end else if (k_q[0]) begin
          sum_d   = (zero_q ? 64'sd0 : st_sample) - ({{32{c_q[31]}}, c_q} <<< 1);
          k_d     = k_q + 3'd1;
          state_d = ST_LAP_READ;
        end else begin
          sum_d   = sum_q + (zero_q ? 64'sd0 : st_sample);
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        mac_cmd.op = MAC_MUL_LO;
        state_d    = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        mac_cmd.op = MAC_MUL_HI;
        state_d    = ST_MUL_ACC;
      end
      ST_MUL_ACC: begin
        mac_cmd.op = MAC_ACC;
        if (op_q == OP_INTEGRAL || k_q == 3'd6) begin
          state_d = ST_ROUND;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = ST_LAP_READ;
        end
      end
      ST_INT_RUN: begin
        if (zero_q) begin
          sum_d = sum_q + st_sample;
        end
        cnt_d = cnt_q + IdxW'(1);
        if (cnt_q == cells - IdxW'(1)) begin
          state_d = ST_INT_TAIL;
        end
      end
      ST_INT_TAIL: begin
        sum_d   = sum_q + st_sample;
        state_d = ST_MUL_LO;
      end
      ST_ROUND: begin
        hold_d  = mac_result;
        hstat_d = 1'b0;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // In the integral sweep, zero_q marks that a read issued last cycle returns now.
    if (state_q == ST_INT_RUN) begin
      zero_d = 1'b1;
    end else if (state_q == ST_DECODE) begin
      zero_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= '0;
      ax_q        <= '0;
      cnt_q       <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      ax_q        <= ax_d;
      cnt_q       <= cnt_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= gls_op_e'(in_i.operation);
      mode_q <= bnd_mode_e'(in_i.boundary_mode);
      cx_q   <= in_i.coord_x;
      cy_q   <= in_i.coord_y;
      cz_q   <= in_i.coord_z;
      wval_q <= in_i.write_value;
    end
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    rz_q    <= rz_d;
    sum_q   <= sum_d;
    c_q     <= c_d;
    hold_q  <= hold_d;
    hstat_q <= hstat_d;
    if (out_load) begin
      out_val_q  <= hold_q;
      out_stat_q <= hstat_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_val_q;
  assign out_o.status       = out_stat_q;

`include "assert_macros.svh"

  `GLS_ASSERT_HOLDS(a_ready_after_clear, !in_i.ready || store_ready, "word accepted during store clear")
  `GLS_ASSERT_HOLDS(a_error_zero, !(out_o.valid && out_o.status) || (out_o.result_value == 64'sd0), "error status with nonzero result")
  `GLS_ASSERT_NEXT(a_accept_decode, accept, state_q == ST_DECODE, "accepted word not decoded")
  `GLS_ASSERT_HOLDS(a_write_decode, !st_we || (state_q == ST_DECODE && op_q == OP_WRITE), "store written outside a cell write")

endmodule

### dv/grid_laplacian_stencil_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_laplacian_stencil_engine_core_test
// Self-checking bench for the grid store, boundary sampler, 7-point
// Laplacian and volume integral. Command words are predicted against a
// private copy of the grid and registers and every result word is checked
// in order. The run walks several grid shapes and scale settings, under
// random stalls on both channels except in phases run without gaps.
// ----------------------------------------------------------------------------
module grid_laplacian_stencil_engine_core_test;
  import gls_pkg::*;

  typedef struct {
    gls_op_e            op;
    logic signed [7:0]  cx;
    logic signed [7:0]  cy;
    logic signed [7:0]  cz;
    logic [1:0]         mode;
    logic signed [31:0] wval;
  } stencil_cmd_t;

  typedef struct {
    logic signed [63:0] value;
    logic               status;
  } stencil_result_t;

  localparam int unsigned IdleLimit = 30000;
  localparam logic signed [127:0] SatHi = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] SatLo = -SatHi - 128'sd1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  gls_in_if  in_ch ();
  gls_out_if out_ch ();

  grid_laplacian_stencil_engine_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Private copy of the block's state.
  logic [31:0] cell_mem [4096];
  logic [4:0]  ext_reg [3];
  logic [31:0] inv_sq [3];
  logic [31:0] vol_reg;

  stencil_cmd_t    cmd_q [$];
  stencil_result_t result_q [$];
  int  send_gap, recv_stall, idle_cycles;
  int  errors, n_checked;
  int  n_op [4];
  bit  no_idle;

  function automatic longint dim_of(int axis);
    longint n;
    n = ext_reg[axis];
    if (n == 0) n = 1;
    if (n > GlsMaxDim) n = GlsMaxDim;
    return n;
  endfunction

  function automatic bit in_grid(longint x, longint y, longint z);
    return x >= 0 && y >= 0 && z >= 0 && x < dim_of(0) && y < dim_of(1) && z < dim_of(2);
  endfunction

  function automatic int unsigned cell_addr(longint x, longint y, longint z);
    longint i;
    i = (z * dim_of(1) + y) * dim_of(0) + x;
    return (i >= 0 && i < 4096) ? int'(i) : 0;
  endfunction

  function automatic longint read_cell(longint x, longint y, longint z);
    logic signed [31:0] v;
    v = cell_mem[cell_addr(x, y, z)];
    return longint'(v);
  endfunction

  function automatic longint wrap_coord(longint c, longint n);
    longint r;
    r = c % n;
    return r < 0 ? r + n : r;
  endfunction

  function automatic longint clamp_coord(longint c, longint n);
    return c < 0 ? 0 : (c > n - 1 ? n - 1 : c);
  endfunction

  function automatic longint bounded_sample(longint x, longint y, longint z, logic [1:0] mode);
    if (in_grid(x, y, z)) return read_cell(x, y, z);
    if (mode == BND_ZERO) return 0;
    if (mode == BND_WRAP)
      return read_cell(wrap_coord(x, dim_of(0)), wrap_coord(y, dim_of(1)),
                       wrap_coord(z, dim_of(2)));
    return read_cell(clamp_coord(x, dim_of(0)), clamp_coord(y, dim_of(1)),
                     clamp_coord(z, dim_of(2)));
  endfunction

  function automatic logic signed [127:0] scaled(longint d, logic [31:0] v);
    return $signed({{64{d[63]}}, d}) * $signed({96'd0, v});
  endfunction

  function automatic logic signed [63:0] round_sat(logic signed [127:0] w);
    w = (w + (128'sd1 <<< (GlsFracBits - 1))) >>> GlsFracBits;
    if (w > SatHi) return SatHi[63:0];
    if (w < SatLo) return SatLo[63:0];
    return w[63:0];
  endfunction

  function automatic stencil_result_t stencil_predict(stencil_cmd_t c);
    stencil_result_t r;
    longint x, y, z, c2, ddx, ddy, ddz, total;
    logic signed [127:0] acc;
    x = c.cx;
    y = c.cy;
    z = c.cz;
    r.value = '0;
    r.status = 1'b0;
    case (c.op)
      OP_WRITE: begin
        if (in_grid(x, y, z)) cell_mem[cell_addr(x, y, z)] = c.wval;
        else r.status = 1'b1;
      end
      OP_SAMPLE: r.value = bounded_sample(x, y, z, c.mode);
      OP_LAPLACE: begin
        if (!in_grid(x, y, z)) begin
          r.status = 1'b1;
        end else begin
          c2 = 2 * read_cell(x, y, z);
          ddx = bounded_sample(x - 1, y, z, c.mode) - c2 + bounded_sample(x + 1, y, z, c.mode);
          ddy = bounded_sample(x, y - 1, z, c.mode) - c2 + bounded_sample(x, y + 1, z, c.mode);
          ddz = bounded_sample(x, y, z - 1, c.mode) - c2 + bounded_sample(x, y, z + 1, c.mode);
          acc = scaled(ddx, inv_sq[0]) + scaled(ddy, inv_sq[1]) + scaled(ddz, inv_sq[2]);
          r.value = round_sat(acc);
        end
      end
      default: begin
        total = 0;
        for (int i = 0; i < dim_of(0) * dim_of(1) * dim_of(2); i++) begin
          total += longint'($signed(cell_mem[i]));
        end
        r.value = round_sat(scaled(total, vol_reg));
      end
    endcase
    return r;
  endfunction

  // Command driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        stencil_cmd_t c;
        c.op = gls_op_e'(in_ch.operation);
        c.cx = in_ch.coord_x;
        c.cy = in_ch.coord_y;
        c.cz = in_ch.coord_z;
        c.mode = in_ch.boundary_mode;
        c.wval = in_ch.write_value;
        result_q.push_back(stencil_predict(c));
        n_op[c.op]++;
        send_gap = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0 || cmd_q.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          stencil_cmd_t n;
          n = cmd_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= n.op;
          in_ch.coord_x <= n.cx;
          in_ch.coord_y <= n.cy;
          in_ch.coord_z <= n.cz;
          in_ch.boundary_mode <= n.mode;
          in_ch.write_value <= n.wval;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        stencil_result_t e;
        n_checked++;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word value=%h status=%b", $time,
                   out_ch.result_value, out_ch.status);
        end else begin
          e = result_q.pop_front();
          if (e.value !== out_ch.result_value || e.status !== out_ch.status) begin
            errors++;
            $display("%0t: mismatch expected value=%h status=%b actual value=%h status=%b",
                     $time, e.value, e.status, out_ch.result_value, out_ch.status);
          end
        end
        recv_stall = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (recv_stall > 0) begin
        out_ch.ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, result_q.size());
      $display("grid_laplacian_stencil_engine_core_test: done, errors");
      $finish;
    end
  end

  task automatic cfg_write(cfg_reg_e r, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: ext_reg[r] = v[4:0];
      REG_INV_DX_SQ, REG_INV_DY_SQ, REG_INV_DZ_SQ: inv_sq[r - REG_INV_DX_SQ] = v;
      default: vol_reg = v;
    endcase
  endtask

  task automatic add_cmd(gls_op_e op, int x, int y, int z, logic [1:0] mode,
                         logic [31:0] wv);
    stencil_cmd_t c;
    c.op = op;
    c.cx = x[7:0];
    c.cy = y[7:0];
    c.cz = z[7:0];
    c.mode = mode;
    c.wval = wv;
    cmd_q.push_back(c);
  endtask

  function automatic int pick_coord(int axis);
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, 32'(dim_of(axis) + 1)) - 1;
  endfunction

  task automatic add_random(int count);
    int sel;
    logic [31:0] wv;
    logic [31:0] edge_vals [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF};
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      wv = ($urandom_range(0, 6) == 0) ? edge_vals[$urandom_range(0, 4)] : $urandom;
      add_cmd(sel < 38 ? OP_WRITE : sel < 63 ? OP_SAMPLE : sel < 97 ? OP_LAPLACE : OP_INTEGRAL,
              pick_coord(0), pick_coord(1), pick_coord(2), 2'($urandom_range(0, 3)), wv);
    end
  endtask

  task automatic wait_idle();
    wait (cmd_q.size() == 0 && result_q.size() == 0 && !in_ch.valid);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [4:0] nx, logic [4:0] ny, logic [4:0] nz,
                          logic [31:0] ix, logic [31:0] iy, logic [31:0] iz, logic [31:0] vol);
    cfg_write(REG_SIZE_X, nx);
    cfg_write(REG_SIZE_Y, ny);
    cfg_write(REG_SIZE_Z, nz);
    cfg_write(REG_INV_DX_SQ, ix);
    cfg_write(REG_INV_DY_SQ, iy);
    cfg_write(REG_INV_DZ_SQ, iz);
    cfg_write(REG_CELL_VOLUME, vol);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    in_ch.boundary_mode = '0;
    in_ch.write_value = '0;
    out_ch.ready = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    idle_cycles = 0;
    errors = 0;
    n_checked = 0;
    no_idle = 1'b0;
    foreach (cell_mem[i]) cell_mem[i] = '0;
    foreach (ext_reg[i]) ext_reg[i] = 5'd16;
    foreach (inv_sq[i]) inv_sq[i] = 32'd65536;
    vol_reg = 32'd65536;
    foreach (n_op[i]) n_op[i] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Corners, rejected coordinates, all boundary modes, integral.
    add_cmd(OP_WRITE, 0, 0, 0, BND_ZERO, 32'h7FFF_FFFF);
    add_cmd(OP_WRITE, 15, 15, 15, BND_ZERO, 32'h8000_0000);
    add_cmd(OP_WRITE, 1, 0, 0, BND_ZERO, 32'hFFFF_0000);
    add_cmd(OP_WRITE, 16, 0, 0, BND_ZERO, 32'h1234_5678);
    add_cmd(OP_WRITE, -1, 3, 3, BND_ZERO, 32'h1);
    add_cmd(OP_WRITE, 0, 0, 127, BND_ZERO, 32'h1);
    add_cmd(OP_SAMPLE, 0, 0, 0, BND_ZERO, '0);
    for (int m = 0; m < 4; m++) begin
      add_cmd(OP_SAMPLE, -128, -128, -128, 2'(m), '0);
      add_cmd(OP_SAMPLE, 127, 127, 127, 2'(m), '0);
      add_cmd(OP_LAPLACE, 0, 0, 0, 2'(m), '0);
      add_cmd(OP_LAPLACE, 15, 15, 15, 2'(m), '0);
    end
    add_cmd(OP_LAPLACE, -1, 0, 0, BND_WRAP, '0);
    add_cmd(OP_LAPLACE, 0, 16, 0, BND_WRAP, '0);
    add_cmd(OP_INTEGRAL, 0, 0, 0, BND_ZERO, '0);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_grid(5'd4, 5'd3, 5'd2, $urandom, $urandom_range(1, 1 << 20), 32'd65536, $urandom);
        1: set_grid(5'd1, 5'd1, 5'd1, '1, '1, '1, '1);
        2: set_grid(5'd0, 5'd31, 5'd5, '0, 32'd1, '0, '0);
        3: set_grid(5'd16, 5'd16, 5'd16, $urandom, $urandom, $urandom, $urandom);
        4: set_grid(5'd7, 5'd2, 5'd9, $urandom, $urandom, $urandom, $urandom_range(1, 65536));
        default: set_grid(5'd3, 5'd3, 5'd3, 32'hFFFF_0000, 32'h8000_0001, '1, 32'h8000_0000);
      endcase
      no_idle = (phase == 1) || ($urandom_range(0, 3) == 0);
      add_random(172);
      wait_idle();
    end

    $display("Checked %0d result words: %0d writes, %0d samples, %0d Laplacians, %0d integrals,",
             n_checked, n_op[OP_WRITE], n_op[OP_SAMPLE], n_op[OP_LAPLACE], n_op[OP_INTEGRAL]);
    $display("over seven grid shapes including degenerate and oversized extents.");
    if (errors == 0) begin
      $display("grid_laplacian_stencil_engine_core_test: done, clean");
    end else begin
      $display("grid_laplacian_stencil_engine_core_test: done, errors");
    end
    $finish;
  end

endmodule
